// ===== rtl/phpd_pkg.sv =====
package phpd_pkg;

    // Gains are signed values with 32 fractional bits.
    localparam int GAIN_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_SHIFT = 18;
    localparam int DRIVE_W    = 16;
    localparam int DRIVE_ONE  = 16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_X  = 3'd0,
        REG_KD_X  = 3'd1,
        REG_KP_Y  = 3'd2,
        REG_KD_Y  = 3'd3,
        REG_KP_Z  = 3'd4,
        REG_KD_Z  = 3'd5,
        REG_K_YAW = 3'd6
    } cfg_reg_t;

    localparam logic signed [GAIN_W-1:0] KP_X_RST  = -32'sd214748;
    localparam logic signed [GAIN_W-1:0] KD_X_RST  = -32'sd85899;
    localparam logic signed [GAIN_W-1:0] KP_Y_RST  = 32'sd300648;
    localparam logic signed [GAIN_W-1:0] KD_Y_RST  = -32'sd85899;
    localparam logic signed [GAIN_W-1:0] KP_Z_RST  = -32'sd214748;
    localparam logic signed [GAIN_W-1:0] KD_Z_RST  = -32'sd64424;
    localparam logic signed [GAIN_W-1:0] K_YAW_RST = -32'sd17179869;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_ADD  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

endpackage

// ===== rtl/phpd_if.sv =====
interface phpd_pose_if #(
    parameter int POS_BITS = 20
);
    logic                       valid;
    logic                       ready;
    logic signed [POS_BITS-1:0] target_x;
    logic signed [POS_BITS-1:0] target_y;
    logic signed [POS_BITS-1:0] target_z;
    logic signed [POS_BITS-1:0] target_yaw;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic signed [POS_BITS-1:0] pos_z;
    logic signed [POS_BITS-1:0] pos_yaw;
    logic        [POS_BITS-1:0] tol_x;
    logic        [POS_BITS-1:0] tol_y;
    logic        [POS_BITS-1:0] tol_z;
    logic        [POS_BITS-1:0] tol_yaw;

    modport source (
        output valid, target_x, target_y, target_z, target_yaw,
               pos_x, pos_y, pos_z, pos_yaw, tol_x, tol_y, tol_z, tol_yaw,
        input  ready
    );
    modport sink (
        input  valid, target_x, target_y, target_z, target_yaw,
               pos_x, pos_y, pos_z, pos_yaw, tol_x, tol_y, tol_z, tol_yaw,
        output ready
    );
endinterface

interface phpd_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_x;
    logic signed [15:0] drive_y;
    logic signed [15:0] drive_z;
    logic signed [15:0] drive_yaw;
    logic               arrived;

    modport source (
        output valid, drive_x, drive_y, drive_z, drive_yaw, arrived,
        input  ready
    );
    modport sink (
        input  valid, drive_x, drive_y, drive_z, drive_yaw, arrived,
        output ready
    );
endinterface

// ===== rtl/position_hold_pd_with_error_average_unit.sv =====
// Position-hold PD controller with a moving average of past errors.
// The pose channel brings one item: target pose, measured pose and
// tolerances. The cmd channel returns one item per pose item: four Q2.14
// drives saturated to plus or minus one, and an arrived flag. Gains are
// written through the plain write port (cfg_we, cfg_index, cfg_data); the
// user must do so only while the block is idle, as the block itself does
// not enforce it. An index past the last gain is ignored. The x, y and z
// errors of each item go into a ring memory of WINDOW entries with a
// registered synchronous read. The mean of the stored errors comes from
// three restoring dividers that retire one quotient bit per cycle; the
// result then passes the multiply, add and done steps into the output
// register, and no new item is accepted until it is loaded there.
// One item is worked at a time; the next item is accepted in the cycle after
// the previous result is loaded into the output register, even while that
// result still waits on cmd.ready. If the receiver stalls, the finished
// item waits in its final step until the output register is free.
// Reset restores the default gains, empties the ring (count, write slot and
// sums go to zero) and clears the output valid flag. The ring contents need no
// clearing: an entry is read for eviction only after it has been written.
module position_hold_pd_with_error_average_unit #(
    parameter int WINDOW   = 33,
    parameter int POS_BITS = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [phpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [phpd_pkg::GAIN_W-1:0]    cfg_data,
    phpd_pose_if.sink                  pose,
    phpd_cmd_if.source                 cmd
);
    import phpd_pkg::*;

    // Error width, running sum width, counters.
    localparam int E_W    = POS_BITS + 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = E_W + CNT_W;
    localparam int ITER_W = $clog2(SUM_W + 1);
    localparam int RING_W = 3 * E_W;
    localparam int M_W    = E_W + 1;
    localparam int P_W    = GAIN_W + E_W + 1;
    localparam int A_W    = P_W + 1;

    localparam logic signed [A_W-1:0] SAT_HI = A_W'(DRIVE_ONE);
    localparam logic signed [A_W-1:0] SAT_LO = -(A_W'(DRIVE_ONE));

    state_t state_reg, state_next;

    logic signed [GAIN_W-1:0] kp_reg [3];
    logic signed [GAIN_W-1:0] kd_reg [3];
    logic signed [GAIN_W-1:0] k_yaw_reg;

    // Per-item working registers. Index 3 is yaw.
    logic signed [E_W-1:0]      e_reg   [4];
    logic        [POS_BITS-1:0] tol_reg [4];

    logic [SLOT_W-1:0]       slot_reg;
    logic [CNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0] sum_reg [3];

    // Ring memory holds x, y, z errors of one item per entry.
    logic [RING_W-1:0] ring_mem [WINDOW];
    logic [RING_W-1:0] rd_data_reg;

    // Dividers: magnitude of the sum shifts out as quotient bits shift in.
    logic [SUM_W-1:0] div_q_reg   [3];
    logic [CNT_W-1:0] div_rem_reg [3];
    logic             div_neg_reg [3];
    logic [ITER_W-1:0] iter_reg;

    logic signed [P_W-1:0] pp_reg [4];
    logic signed [P_W-1:0] pd_reg [3];

    logic signed [DRIVE_W-1:0] drv_reg [4];
    logic                      arr_reg;

    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] out_drv_reg [4];
    logic                      out_arr_reg;

    logic accept;
    logic out_free;

    assign pose.ready = (state_reg == S_IDLE);
    assign accept     = pose.valid && pose.ready;
    assign out_free   = !out_valid_reg || cmd.ready;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg[0] <= KP_X_RST;
            kd_reg[0] <= KD_X_RST;
            kp_reg[1] <= KP_Y_RST;
            kd_reg[1] <= KD_Y_RST;
            kp_reg[2] <= KP_Z_RST;
            kd_reg[2] <= KD_Z_RST;
            k_yaw_reg <= K_YAW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KP_X:  kp_reg[0] <= cfg_data;
                REG_KD_X:  kd_reg[0] <= cfg_data;
                REG_KP_Y:  kp_reg[1] <= cfg_data;
                REG_KD_Y:  kd_reg[1] <= cfg_data;
                REG_KP_Z:  kp_reg[2] <= cfg_data;
                REG_KD_Z:  kd_reg[2] <= cfg_data;
                REG_K_YAW: k_yaw_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_DIV;
            S_DIV:  if (iter_reg == ITER_W'(1)) state_next = S_MUL;
            S_MUL:  state_next = S_ADD;
            S_ADD:  state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- capture of an item and memory read ----------------
    function automatic logic signed [E_W-1:0] err_of(
        input logic [POS_BITS-1:0] p,
        input logic [POS_BITS-1:0] t
    );
        return $signed({p[POS_BITS-1], p}) - $signed({t[POS_BITS-1], t});
    endfunction

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_reg[0]   <= err_of(pose.pos_x, pose.target_x);
            e_reg[1]   <= err_of(pose.pos_y, pose.target_y);
            e_reg[2]   <= err_of(pose.pos_z, pose.target_z);
            e_reg[3]   <= err_of(pose.pos_yaw, pose.target_yaw);
            tol_reg[0] <= pose.tol_x;
            tol_reg[1] <= pose.tol_y;
            tol_reg[2] <= pose.tol_z;
            tol_reg[3] <= pose.tol_yaw;
            rd_data_reg <= ring_mem[slot_reg];
        end
        if (state_reg == S_MUL)
            ring_mem[slot_reg] <= {e_reg[2], e_reg[1], e_reg[0]};
    end

    // ---------------- dividers ----------------
    logic [CNT_W:0]   rem_shift [3];
    logic             rem_ge    [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            rem_shift[a] = {div_rem_reg[a], div_q_reg[a][SUM_W-1]};
            rem_ge[a]    = (rem_shift[a] >= {1'b0, count_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iter_reg <= '0;
        else if (accept)
            iter_reg <= ITER_W'(SUM_W);
        else if (state_reg == S_DIV)
            iter_reg <= iter_reg - ITER_W'(1);
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (accept)
            begin
                div_neg_reg[a] <= sum_reg[a][SUM_W-1];
                div_q_reg[a]   <= sum_reg[a][SUM_W-1] ? SUM_W'(-sum_reg[a])
                                                      : SUM_W'(sum_reg[a]);
                div_rem_reg[a] <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                div_q_reg[a]   <= {div_q_reg[a][SUM_W-2:0], rem_ge[a]};
                div_rem_reg[a] <= rem_ge[a]
                    ? CNT_W'(rem_shift[a] - {1'b0, count_reg})
                    : CNT_W'(rem_shift[a]);
            end
        end
    end

    // ---------------- ring bookkeeping ----------------
    logic signed [E_W-1:0] old_e [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            old_e[a] = $signed(rd_data_reg[a*E_W +: E_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            count_reg <= '0;
            for (int a = 0; a < 3; a++)
                sum_reg[a] <= '0;
        end
        else if (state_reg == S_MUL)
        begin
            slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0
                                                          : slot_reg + SLOT_W'(1);
            if (count_reg == CNT_W'(WINDOW))
            begin
                for (int a = 0; a < 3; a++)
                    sum_reg[a] <= sum_reg[a] - SUM_W'(old_e[a]) + SUM_W'(e_reg[a]);
            end
            else
            begin
                count_reg <= count_reg + CNT_W'(1);
                for (int a = 0; a < 3; a++)
                    sum_reg[a] <= sum_reg[a] + SUM_W'(e_reg[a]);
            end
        end
    end

    // ---------------- products ----------------
    logic signed [M_W-1:0] mean [3];
    logic signed [M_W-1:0] neg_e [4];
    logic signed [M_W-1:0] mag_q [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mag_q[a] = $signed({1'b0, div_q_reg[a][E_W-1:0]});
            if (count_reg == '0)
                mean[a] = '0;
            else
                mean[a] = div_neg_reg[a] ? -mag_q[a] : mag_q[a];
        end
        for (int a = 0; a < 4; a++)
            neg_e[a] = -$signed({e_reg[a][E_W-1], e_reg[a]});
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            for (int a = 0; a < 3; a++)
            begin
                pp_reg[a] <= kp_reg[a] * neg_e[a];
                pd_reg[a] <= kd_reg[a] * mean[a];
            end
            pp_reg[3] <= k_yaw_reg * neg_e[3];
        end
    end

    // ---------------- sum, scale, saturate ----------------
    logic signed [A_W-1:0]  acc   [4];
    logic signed [A_W-1:0]  shf   [4];
    logic signed [DRIVE_W-1:0] sat [4];
    logic        [E_W:0]    abs_e [4];
    logic signed [E_W:0]    ext_e [4];
    logic                   yaw_on;
    logic                   arr_now;

    always_comb
    begin
        for (int a = 0; a < 4; a++)
        begin
            if (a < 3)
                acc[a] = A_W'(pp_reg[a]) + A_W'(pd_reg[a]);
            else
                acc[a] = A_W'(pp_reg[a]);
            // Floor shift to Q2.14, then clamp to plus or minus one.
            shf[a] = acc[a] >>> FRAC_SHIFT;
            if (shf[a] > SAT_HI)
                sat[a] = DRIVE_W'(DRIVE_ONE);
            else if (shf[a] < SAT_LO)
                sat[a] = -(DRIVE_W'(DRIVE_ONE));
            else
                sat[a] = shf[a][DRIVE_W-1:0];
            ext_e[a] = {e_reg[a][E_W-1], e_reg[a]};
            abs_e[a] = ext_e[a][E_W] ? unsigned'(-ext_e[a]) : unsigned'(ext_e[a]);
        end
        yaw_on  = abs_e[3] > {1'b0, tol_reg[3]};
        arr_now = (abs_e[0] < {1'b0, tol_reg[0]})
               && (abs_e[1] < {1'b0, tol_reg[1]})
               && (abs_e[2] < {1'b0, tol_reg[2]});
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD)
        begin
            drv_reg[0] <= sat[0];
            drv_reg[1] <= sat[1];
            drv_reg[2] <= sat[2];
            drv_reg[3] <= yaw_on ? sat[3] : '0;
            arr_reg    <= arr_now;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (cmd.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            for (int a = 0; a < 4; a++)
                out_drv_reg[a] <= drv_reg[a];
            out_arr_reg <= arr_reg;
        end
    end

    assign cmd.valid     = out_valid_reg;
    assign cmd.drive_x   = out_drv_reg[0];
    assign cmd.drive_y   = out_drv_reg[1];
    assign cmd.drive_z   = out_drv_reg[2];
    assign cmd.drive_yaw = out_drv_reg[3];
    assign cmd.arrived   = out_arr_reg;

endmodule

// ===== tb/phpd_check.sv =====
module phpd_check #(
    parameter int WINDOW   = 33,
    parameter int POS_BITS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [phpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [phpd_pkg::GAIN_W-1:0]     cfg_data,
    phpd_pose_if                            pose,
    phpd_cmd_if                             cmd,
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import phpd_pkg::*;

    typedef struct {
        logic signed [15:0] drive_x;
        logic signed [15:0] drive_y;
        logic signed [15:0] drive_z;
        logic signed [15:0] drive_yaw;
        logic               arrived;
    } cmd_t;

    localparam longint SAT = longint'(DRIVE_ONE) <<< FRAC_SHIFT;

    longint gain [7];
    longint err_ring [WINDOW][3];
    int     wr_slot;
    int     fill;
    longint sums [3];
    cmd_t   cmd_queue [$];

    assign pending = cmd_queue.size();

    function automatic logic signed [15:0] saturate_q214(longint acc);
        if (acc >= SAT)
            return 16'(DRIVE_ONE);
        if (acc <= -SAT)
            return -16'(DRIVE_ONE);
        return 16'(acc >>> FRAC_SHIFT);
    endfunction

    function automatic longint abs_l(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Works out the command for one pose item and pushes its errors into the ring.
    function automatic cmd_t predict_cmd();
        cmd_t   c;
        longint e [3];
        longint eyaw;
        longint m;
        longint tol [3];
        logic signed [15:0] d [3];
        e[0] = longint'(pose.pos_x) - longint'(pose.target_x);
        e[1] = longint'(pose.pos_y) - longint'(pose.target_y);
        e[2] = longint'(pose.pos_z) - longint'(pose.target_z);
        eyaw = longint'(pose.pos_yaw) - longint'(pose.target_yaw);
        tol[0] = longint'({1'b0, pose.tol_x});
        tol[1] = longint'({1'b0, pose.tol_y});
        tol[2] = longint'({1'b0, pose.tol_z});
        for (int a = 0; a < 3; a++) begin
            m = (fill == 0) ? 0 : sums[a] / fill;
            d[a] = saturate_q214(gain[2*a] * (-e[a]) + gain[2*a+1] * m);
        end
        c.drive_x = d[0];
        c.drive_y = d[1];
        c.drive_z = d[2];
        c.drive_yaw = 0;
        if (abs_l(eyaw) > longint'({1'b0, pose.tol_yaw}))
            c.drive_yaw = saturate_q214(gain[REG_K_YAW] * (-eyaw));
        c.arrived = abs_l(e[0]) < tol[0] && abs_l(e[1]) < tol[1] && abs_l(e[2]) < tol[2];
        for (int a = 0; a < 3; a++) begin
            if (fill >= WINDOW)
                sums[a] -= err_ring[wr_slot][a];
            err_ring[wr_slot][a] = e[a];
            sums[a] += e[a];
        end
        if (fill < WINDOW)
            fill++;
        wr_slot = (wr_slot + 1) % WINDOW;
        return c;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n) begin
        cmd_t want;
        cmd_t next_want;
        if (!rst_n) begin
            gain[REG_KP_X] = KP_X_RST;
            gain[REG_KD_X] = KD_X_RST;
            gain[REG_KP_Y] = KP_Y_RST;
            gain[REG_KD_Y] = KD_Y_RST;
            gain[REG_KP_Z] = KP_Z_RST;
            gain[REG_KD_Z] = KD_Z_RST;
            gain[REG_K_YAW] = K_YAW_RST;
            wr_slot = 0;
            fill = 0;
            sums = '{0, 0, 0};
            cmd_queue.delete();
        end else begin
            if (cfg_we && cfg_index <= REG_K_YAW)
                gain[cfg_index] = longint'($signed(cfg_data));
            if (cmd.valid && cmd.ready) begin
                if (cmd_queue.size() == 0) begin
                    report("unexpected command item", 1, 0);
                end else begin
                    want = cmd_queue.pop_front();
                    if (cmd.drive_x !== want.drive_x)
                        report("drive_x", cmd.drive_x, want.drive_x);
                    if (cmd.drive_y !== want.drive_y)
                        report("drive_y", cmd.drive_y, want.drive_y);
                    if (cmd.drive_z !== want.drive_z)
                        report("drive_z", cmd.drive_z, want.drive_z);
                    if (cmd.drive_yaw !== want.drive_yaw)
                        report("drive_yaw", cmd.drive_yaw, want.drive_yaw);
                    if (cmd.arrived !== want.arrived)
                        report("arrived", cmd.arrived, want.arrived);
                end
            end
            if (pose.valid && pose.ready) begin
                next_want = predict_cmd();
                cmd_queue.insert(cmd_queue.size(), next_want);
            end
        end
    end

endmodule

// ===== tb/position_hold_pd_with_error_average_unit_test.sv =====
module position_hold_pd_with_error_average_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import phpd_pkg::*;

    localparam int POS_BITS = 20;
    localparam int WINDOW   = 33;
    // Index past the last gain; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // Settle time for draining, taken with margin over the work of one item.
    localparam int SETTLE     = 60;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_STALL = 300;
    localparam logic [POS_BITS-1:0] PMAX = 20'h7FFFF;
    localparam logic [POS_BITS-1:0] PMIN = 20'h80000;
    localparam logic [POS_BITS-1:0] UMAX = 20'hFFFFF;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_data;
    int                   errors;
    int                   pending;
    bit                   quiet;
    bit                   stall_long;
    int                   idle_cycles;

    phpd_pose_if #(.POS_BITS(POS_BITS)) pose ();
    phpd_cmd_if                         cmd ();

    position_hold_pd_with_error_average_unit #(
        .WINDOW  (WINDOW),
        .POS_BITS(POS_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .pose     (pose),
        .cmd      (cmd)
    );

    phpd_check #(
        .WINDOW  (WINDOW),
        .POS_BITS(POS_BITS)
    ) i_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .pose     (pose),
        .cmd      (cmd),
        .errors   (errors),
        .pending  (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Every input starts at a known value before the first edge.
    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KP_X;
        cfg_data = '0;
        pose.valid = 1'b0;
        {pose.target_x, pose.target_y, pose.target_z, pose.target_yaw} = '0;
        {pose.pos_x, pose.pos_y, pose.pos_z, pose.pos_yaw} = '0;
        {pose.tol_x, pose.tol_y, pose.tol_z, pose.tol_yaw} = '0;
        cmd.ready = 1'b0;
        quiet = 1'b0;
        stall_long = 1'b0;
    end

    // Receiver side. A request for a long stall holds ready low through a long
    // stall while the sender keeps offering pose items, so the block fills up
    // and must hold off its input. Otherwise ready drops in short random bursts,
    // except in the final quiet part of the run.
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (stall_long) begin
                cmd.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                stall_long = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                cmd.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end else begin
                cmd.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a run in which no item moves on either channel for too long is hung.
    always @(posedge clk) begin
        if ((pose.valid && pose.ready) || (cmd.valid && cmd.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial idle_cycles = 0;

    // Offers one pose item and waits for the edge where it is taken. Outside the
    // quiet part it then sometimes lowers valid for a short random pause.
    task automatic send_pose(
        input logic [POS_BITS-1:0] tx, ty, tz, tyaw,
        input logic [POS_BITS-1:0] px, py, pz, pyaw,
        input logic [POS_BITS-1:0] lx, ly, lz, lyaw
    );
        pose.valid <= 1'b1;
        pose.target_x <= tx;
        pose.target_y <= ty;
        pose.target_z <= tz;
        pose.target_yaw <= tyaw;
        pose.pos_x <= px;
        pose.pos_y <= py;
        pose.pos_z <= pz;
        pose.pos_yaw <= pyaw;
        pose.tol_x <= lx;
        pose.tol_y <= ly;
        pose.tol_z <= lz;
        pose.tol_yaw <= lyaw;
        do
            @(posedge clk);
        while (!pose.ready);
        if (!quiet && $urandom_range(0, 6) == 0) begin
            pose.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // A tolerance near the error magnitude, so strict comparisons are probed at
    // the boundary; sometimes zero, a small random value or fully random.
    function automatic logic [POS_BITS-1:0] pick_tol(logic signed [POS_BITS:0] err);
        logic [POS_BITS:0] mag;
        mag = err < 0 ? -err : err;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return POS_BITS'($urandom);
            2: return mag[POS_BITS-1:0];
            3: return mag[POS_BITS-1:0] + 1'b1;
            default: return POS_BITS'($urandom_range(0, 4000));
        endcase
    endfunction

    // Random pose: mostly a measured pose close to the target, so averages and
    // drives stay off the rails; the rest spans the whole field range.
    task automatic send_random_pose();
        logic [POS_BITS-1:0]     t [4];
        logic [POS_BITS-1:0]     p [4];
        logic signed [POS_BITS:0] e [4];
        bit wide;
        wide = ($urandom_range(0, 3) == 0);
        for (int a = 0; a < 4; a++) begin
            t[a] = POS_BITS'($urandom);
            if (wide)
                p[a] = POS_BITS'($urandom);
            else
                p[a] = t[a] + POS_BITS'(int'($urandom_range(0, 4000)) - 2000);
            e[a] = $signed({p[a][POS_BITS-1], p[a]}) - $signed({t[a][POS_BITS-1], t[a]});
        end
        send_pose(t[0], t[1], t[2], t[3], p[0], p[1], p[2], p[3],
                  pick_tol(e[0]), pick_tol(e[1]), pick_tol(e[2]), pick_tol(e[3]));
    endtask

    task automatic write_gains(input logic [GAIN_W-1:0] g [7]);
        for (int r = REG_KP_X; r <= REG_K_YAW; r++) begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data <= g[r];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Gains may change only with the block idle: every command has arrived and
    // the block has had time to finish any work in flight.
    task automatic drain();
        pose.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial begin
        logic [GAIN_W-1:0] g [7];

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the default gains. The first one meets an empty
        // ring, so the averaged term is zero.
        send_pose(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0);
        send_pose(PMAX, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, PMIN, UMAX, UMAX, UMAX, UMAX);
        send_pose(PMIN, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, PMAX, 0, 0, 0, 0);
        send_pose(100, 200, 300, 400, 110, 190, 305, 410, 11, 11, 6, 10);
        send_pose(100, 200, 300, 400, 110, 190, 305, 411, 10, 10, 5, 10);
        send_pose(0, 0, 0, 1000, 0, 0, 0, 0, 0, 5, 5, 1000);
        send_pose(0, 0, 0, 0, 0, 0, 0, 1000, 5, 0, 5, 999);
        send_pose(5, 5, 5, 0, 5, 5, 5, 0, 1, 1, 1, 0);
        send_pose(5, 5, 5, 0, 5, 5, 5, 0, 0, 1, 1, 0);
        send_pose(-20'sd3, 7, -20'sd9, 0, 3, -20'sd7, 9, 0, 7, 15, 19, 0);
        send_pose(0, 0, 0, 0, PMAX, 0, 0, 0, UMAX, 1, 1, 0);
        send_pose(0, 0, 0, 0, 0, PMIN, 0, PMAX, 1, UMAX, 1, PMAX);
        send_pose(0, 0, 0, 0, 0, 0, PMAX, PMIN, 1, 1, UMAX, UMAX);
        send_pose(PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, 1, 1, 1, 0);
        // Enough well-formed items to fill the ring and start evicting.
        for (int i = 0; i < 40; i++)
            send_random_pose();
        for (int i = 0; i < 250; i++)
            send_random_pose();
        drain();

        // Largest positive gains, with one long receiver stall on the way.
        g = '{default: 32'h7FFF_FFFF};
        write_gains(g);
        for (int i = 0; i < 250; i++) begin
            if (i == 40)
                stall_long = 1'b1;
            send_random_pose();
        end
        drain();

        // Most negative gains.
        g = '{default: 32'h8000_0000};
        write_gains(g);
        for (int i = 0; i < 250; i++)
            send_random_pose();
        drain();

        // Fully random gains.
        foreach (g[r])
            g[r] = $urandom;
        write_gains(g);
        for (int i = 0; i < 250; i++)
            send_random_pose();
        drain();

        // Zero gains: every drive is zero and only the flag carries information.
        g = '{default: 32'h0};
        write_gains(g);
        for (int i = 0; i < 150; i++)
            send_random_pose();
        drain();

        // Small random gains of either sign; a write to the unused index must change
        // nothing.
        foreach (g[r])
            g[r] = GAIN_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
        write_gains(g);
        cfg_we <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_data <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        for (int i = 0; i < 250; i++)
            send_random_pose();
        drain();

        // Default gains again, with no idling on either side.
        g = '{KP_X_RST, KD_X_RST, KP_Y_RST, KD_Y_RST, KP_Z_RST, KD_Z_RST, K_YAW_RST};
        write_gains(g);
        quiet = 1'b1;
        for (int i = 0; i < 250; i++)
            send_random_pose();
        drain();

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/phpd_pkg.sv
rtl/phpd_if.sv
rtl/position_hold_pd_with_error_average_unit.sv
tb/phpd_check.sv
tb/position_hold_pd_with_error_average_unit_test.sv
